// ----- rtl/core/owms_pkg.sv -----
// ------------------------------------------------------------------------------------------
// owms_pkg: shared types and constants of the single-wire bus master
// Item and result structures, command codes, register indexes and the fixed
// command sequences used by the conversion and temperature commands.
// ------------------------------------------------------------------------------------------
`default_nettype none

package owms_pkg;

	// Command codes carried in the func field.
	localparam logic [2:0] FUNC_TICK    = 3'd0;
	localparam logic [2:0] FUNC_RESET   = 3'd1;
	localparam logic [2:0] FUNC_WRITE   = 3'd2;
	localparam logic [2:0] FUNC_READ    = 3'd3;
	localparam logic [2:0] FUNC_CONVERT = 3'd4;
	localparam logic [2:0] FUNC_TEMP    = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
	localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd1;
	localparam logic [2:0] CFG_RECOVERY      = 3'd2;
	localparam logic [2:0] CFG_SLOT          = 3'd3;
	localparam logic [2:0] CFG_WRITE_LOW     = 3'd4;
	localparam logic [2:0] CFG_READ_SAMPLE   = 3'd5;

	// Register values after reset.
	localparam logic [9:0] RST_RESET_LOW     = 10'd550;
	localparam logic [9:0] RST_PRESENCE_WAIT = 10'd70;
	localparam logic [9:0] RST_RECOVERY      = 10'd500;
	localparam logic [9:0] RST_SLOT          = 10'd70;
	localparam logic [5:0] RST_WRITE_LOW     = 6'd5;
	localparam logic [5:0] RST_READ_SAMPLE   = 6'd8;

	// ROM commands sent by the compound commands.
	localparam logic [7:0] ROM_SKIP    = 8'hCC;
	localparam logic [7:0] CONVERT_T   = 8'h44;
	localparam logic [7:0] READ_SCRPAD = 8'hBE;

	// Queue depths between the parts of the block.
	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);
	localparam int RDepth = 4;
	localparam int RPtrW  = $clog2(RDepth);
	localparam int RCntW  = $clog2(RDepth + 1);

	// Kinds of bus operation that one sequence step performs.
	typedef enum logic [1:0] {
		KIND_RST = 2'd0,
		KIND_WR  = 2'd1,
		KIND_RD  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] wbyte;
	} step_op_t;

	// One tick as presented on the input side.
	typedef struct packed {
		logic [2:0] func;
		logic [7:0] write_data;
		logic       line_sample;
	} in_item_t;

	// One tick after classification, with unused codes folded to a plain tick.
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] write_data;
		logic       line_sample;
	} cls_item_t;

	// One result as presented on the output side.
	typedef struct packed {
		logic        line_release;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_data;
	} out_item_t;

	// A configuration write as passed to the sequencer.
	typedef struct packed {
		logic       valid;
		logic [2:0] index;
		logic [9:0] data;
	} cfg_write_t;

	// The eight steps of the temperature sequence; start conversion runs the last three.
	function automatic step_op_t seq_op(input logic [2:0] idx);
		step_op_t op;
		op.kind  = KIND_RST;
		op.wbyte = 8'h00;
		unique case (idx)
			3'd0: begin op.kind = KIND_RST; op.wbyte = 8'h00; end
			3'd1: begin op.kind = KIND_WR;  op.wbyte = ROM_SKIP; end
			3'd2: begin op.kind = KIND_WR;  op.wbyte = READ_SCRPAD; end
			3'd3: begin op.kind = KIND_RD;  op.wbyte = 8'h00; end
			3'd4: begin op.kind = KIND_RD;  op.wbyte = 8'h00; end
			3'd5: begin op.kind = KIND_RST; op.wbyte = 8'h00; end
			3'd6: begin op.kind = KIND_WR;  op.wbyte = ROM_SKIP; end
			3'd7: begin op.kind = KIND_WR;  op.wbyte = CONVERT_T; end
			default: begin op.kind = KIND_RST; op.wbyte = 8'h00; end
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/owms_front.sv -----
// ------------------------------------------------------------------------------------------
// owms_front: input stage of the single-wire bus master
// Accepts ticks, folds meaningless command codes to a plain tick and holds the
// classified ticks in a short queue until the sequencer takes them.
// ------------------------------------------------------------------------------------------
`default_nettype none

module owms_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	output logic                  full,
	input  owms_pkg::in_item_t    in_data,
	output logic                  q_valid,
	output owms_pkg::cls_item_t   q_item,
	input  wire                   q_take
);

	owms_pkg::cls_item_t              fq_mem_q [owms_pkg::QDepth];
	logic [owms_pkg::QPtrW-1:0]       wr_ptr_q;
	logic [owms_pkg::QPtrW-1:0]       rd_ptr_q;
	logic [owms_pkg::QCntW-1:0]       count_q;
	owms_pkg::cls_item_t              cls_item;
	logic                             do_push;
	logic                             do_pop;

	// Classify the incoming tick: codes above read temperature act as a plain tick.
	always_comb begin
		cls_item.write_data  = in_data.write_data;
		cls_item.line_sample = in_data.line_sample;
		if (in_data.func > owms_pkg::FUNC_TEMP) begin
			cls_item.cmd = owms_pkg::FUNC_TICK;
		end else begin
			cls_item.cmd = in_data.func;
		end
	end

	assign full    = (count_q == owms_pkg::QCntW'(owms_pkg::QDepth));
	assign q_valid = (count_q != '0);
	assign q_item  = fq_mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	// Queue storage is written on every input transfer.
	always_ff @(posedge clk) begin
		if (do_push) begin
			fq_mem_q[wr_ptr_q] <= cls_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPtrOne;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrOne;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCntOne;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCntOne;
			end
		end
	end

	localparam logic [owms_pkg::QPtrW-1:0] QPtrOne = owms_pkg::QPtrW'(1);
	localparam logic [owms_pkg::QCntW-1:0] QCntOne = owms_pkg::QCntW'(1);

endmodule

`default_nettype wire

// ----- rtl/core/owms_seq.sv -----
// ------------------------------------------------------------------------------------------
// owms_seq: bus sequencer of the single-wire bus master
// Holds the timing registers and the bus state machine, evaluates one tick per
// clock while the result queue has room, and produces the line level and status of that tick.
// ------------------------------------------------------------------------------------------
`default_nettype none

module owms_seq (
	input  wire                   clk,
	input  wire                   arst_n,
	input  owms_pkg::cfg_write_t  cfg_wr,
	input  wire                   q_valid,
	input  owms_pkg::cls_item_t   q_item,
	output logic                  q_take,
	input  wire                   res_full,
	output logic                  res_push,
	output owms_pkg::out_item_t   res_item
);

	// Bus phases.
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_RLOW  = 4'd1;
	localparam logic [3:0] PH_RWAIT = 4'd2;
	localparam logic [3:0] PH_RREC  = 4'd3;
	localparam logic [3:0] PH_WLOW  = 4'd4;
	localparam logic [3:0] PH_WSLOT = 4'd5;
	localparam logic [3:0] PH_DLOW  = 4'd6;
	localparam logic [3:0] PH_DREL  = 4'd7;
	localparam logic [3:0] PH_DSLOT = 4'd8;

	// Timing registers.
	logic [9:0] reset_low_q;
	logic [9:0] presence_wait_q;
	logic [9:0] recovery_q;
	logic [9:0] slot_q;
	logic [5:0] write_low_q;
	logic [5:0] read_sample_q;

	// Sequencer state.
	logic [3:0] phase_q;
	logic [9:0] tick_q;
	logic [3:0] bit_q;
	logic [7:0] shift_q;
	logic [7:0] low_temp_q;
	logic [7:0] high_temp_q;
	logic [3:0] step_q;
	logic [2:0] active_q;

	// Next-state values.
	logic [3:0] ph;
	logic [9:0] tc;
	logic [3:0] bc;
	logic [7:0] sb;
	logic [7:0] lt;
	logic [7:0] ht;
	logic [3:0] st;
	logic [2:0] ac;
	logic       line;
	logic       busy;
	logic       fin;
	logic       step_end;
	logic [15:0] rdata;
	logic [3:0] seq_len;
	owms_pkg::step_op_t op;
	logic [5:0] sample_len;
	logic [6:0] sample_inc;
	logic [5:0] low_part;
	logic [5:0] rel_part;

	// A zero length register acts as one tick.
	function automatic logic [9:0] dur(input logic [9:0] x);
		return (x == '0) ? 10'd1 : x;
	endfunction

	// True on the last tick of a phase of the given length.
	function automatic logic at_end(input logic [9:0] tc_in, input logic [9:0] d);
		return ({1'b0, tc_in} + 11'd1) >= {1'b0, d};
	endfunction

	// Operation of a given step of the active command.
	function automatic owms_pkg::step_op_t step_for(input logic [2:0] cmd,
			input logic [3:0] step, input logic [7:0] wd);
		owms_pkg::step_op_t r;
		logic [2:0] idx;
		idx = step[2:0];
		priority if (cmd == owms_pkg::FUNC_RESET) begin
			r.kind  = owms_pkg::KIND_RST;
			r.wbyte = 8'h00;
		end else if (cmd == owms_pkg::FUNC_WRITE) begin
			r.kind  = owms_pkg::KIND_WR;
			r.wbyte = wd;
		end else if (cmd == owms_pkg::FUNC_READ) begin
			r.kind  = owms_pkg::KIND_RD;
			r.wbyte = 8'h00;
		end else begin
			if (cmd == owms_pkg::FUNC_CONVERT) begin
				idx = idx + 3'd5;
			end
			r = owms_pkg::seq_op(idx);
		end
		return r;
	endfunction

	// First phase of a step.
	function automatic logic [3:0] first_phase(input owms_pkg::kind_t k);
		logic [3:0] p;
		unique case (k)
			owms_pkg::KIND_RST: p = PH_RLOW;
			owms_pkg::KIND_WR:  p = PH_WLOW;
			default:            p = PH_DLOW;
		endcase
		return p;
	endfunction

	assign q_take   = q_valid && !res_full;
	assign res_push = q_take;

	// Read slot split: low for the first half (rounded up), released for the rest.
	always_comb begin
		sample_len = (read_sample_q == '0) ? 6'd1 : read_sample_q;
		sample_inc = {1'b0, sample_len} + 7'd1;
		low_part   = sample_inc[6:1];
		rel_part   = sample_len - low_part;
	end

	// Number of steps in the active command.
	always_comb begin
		unique case (ac)
			owms_pkg::FUNC_CONVERT: seq_len = 4'd3;
			owms_pkg::FUNC_TEMP:    seq_len = 4'd8;
			default:                seq_len = 4'd1;
		endcase
	end

	// Evaluation of one tick.
	always_comb begin
		ph       = phase_q;
		tc       = tick_q;
		bc       = bit_q;
		sb       = shift_q;
		lt       = low_temp_q;
		ht       = high_temp_q;
		st       = step_q;
		ac       = active_q;
		line     = 1'b1;
		fin      = 1'b0;
		step_end = 1'b0;
		rdata    = 16'h0000;
		op       = step_for(q_item.cmd, 4'd0, q_item.write_data);

		// A command starts on an idle tick, which is already its first tick.
		if (phase_q == PH_IDLE && q_item.cmd != owms_pkg::FUNC_TICK) begin
			ac = q_item.cmd;
			st = 4'd0;
			tc = 10'd0;
			bc = 4'd0;
			ph = first_phase(op.kind);
			if (op.kind == owms_pkg::KIND_WR) begin
				sb = op.wbyte;
			end else if (op.kind == owms_pkg::KIND_RD) begin
				sb = 8'h00;
			end
		end

		busy = (ph != PH_IDLE);

		// Timed phases of the bus.
		unique case (ph)
			PH_IDLE: begin
			end
			PH_RLOW: begin
				line = 1'b0;
				if (at_end(tc, dur(reset_low_q))) begin
					tc = 10'd0;
					ph = PH_RWAIT;
				end else begin
					tc = tc + 10'd1;
				end
			end
			PH_RWAIT: begin
				if (at_end(tc, dur(presence_wait_q))) begin
					tc = 10'd0;
					ph = q_item.line_sample ? PH_RLOW : PH_RREC;
				end else begin
					tc = tc + 10'd1;
				end
			end
			PH_RREC: begin
				if (at_end(tc, dur(recovery_q))) begin
					tc = 10'd0;
					if (q_item.line_sample) begin
						step_end = 1'b1;
					end else begin
						ph = PH_RLOW;
					end
				end else begin
					tc = tc + 10'd1;
				end
			end
			PH_WLOW: begin
				line = 1'b0;
				if (at_end(tc, dur({4'd0, write_low_q}))) begin
					tc = 10'd0;
					ph = PH_WSLOT;
				end else begin
					tc = tc + 10'd1;
				end
			end
			PH_WSLOT: begin
				line = sb[0];
				if (at_end(tc, dur(slot_q))) begin
					tc = 10'd0;
					sb = {1'b0, sb[7:1]};
					bc = bc + 4'd1;
					if (bc >= 4'd8) begin
						step_end = 1'b1;
					end else begin
						ph = PH_WLOW;
					end
				end else begin
					tc = tc + 10'd1;
				end
			end
			PH_DLOW: begin
				line = 1'b0;
				if (at_end(tc, {4'd0, low_part})) begin
					tc = 10'd0;
					ph = (rel_part != '0) ? PH_DREL : PH_DSLOT;
				end else begin
					tc = tc + 10'd1;
				end
			end
			PH_DREL: begin
				if (at_end(tc, {4'd0, rel_part})) begin
					tc = 10'd0;
					ph = PH_DSLOT;
				end else begin
					tc = tc + 10'd1;
				end
			end
			PH_DSLOT: begin
				// The line is sampled on the first released tick of the slot.
				if (tc == 10'd0) begin
					sb = {q_item.line_sample, sb[7:1]};
				end
				if (at_end(tc, dur(slot_q))) begin
					tc = 10'd0;
					bc = bc + 4'd1;
					if (bc >= 4'd8) begin
						if (ac == owms_pkg::FUNC_TEMP && st == 4'd3) begin
							lt = sb;
						end
						if (ac == owms_pkg::FUNC_TEMP && st == 4'd4) begin
							ht = sb;
						end
						step_end = 1'b1;
					end else begin
						ph = PH_DLOW;
					end
				end else begin
					tc = tc + 10'd1;
				end
			end
			default: begin
				ph = PH_IDLE;
				tc = 10'd0;
			end
		endcase

		// Step completion: move to the next step or finish the command.
		if (step_end) begin
			st = st + 4'd1;
			if (st >= seq_len) begin
				ph  = PH_IDLE;
				tc  = 10'd0;
				fin = 1'b1;
			end else begin
				op = step_for(ac, st, 8'h00);
				tc = 10'd0;
				bc = 4'd0;
				ph = first_phase(op.kind);
				if (op.kind == owms_pkg::KIND_WR) begin
					sb = op.wbyte;
				end else if (op.kind == owms_pkg::KIND_RD) begin
					sb = 8'h00;
				end
			end
		end

		// Read data is shown only on the completing tick.
		if (fin) begin
			if (ac == owms_pkg::FUNC_READ) begin
				rdata = {8'h00, sb};
			end else if (ac == owms_pkg::FUNC_TEMP) begin
				rdata = {ht, lt};
			end
		end

		res_item.line_release = line;
		res_item.busy_res     = busy;
		res_item.done_res     = fin;
		res_item.read_data    = rdata;
	end

	// Timing registers, written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q     <= owms_pkg::RST_RESET_LOW;
			presence_wait_q <= owms_pkg::RST_PRESENCE_WAIT;
			recovery_q      <= owms_pkg::RST_RECOVERY;
			slot_q          <= owms_pkg::RST_SLOT;
			write_low_q     <= owms_pkg::RST_WRITE_LOW;
			read_sample_q   <= owms_pkg::RST_READ_SAMPLE;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				owms_pkg::CFG_RESET_LOW:     reset_low_q     <= cfg_wr.data;
				owms_pkg::CFG_PRESENCE_WAIT: presence_wait_q <= cfg_wr.data;
				owms_pkg::CFG_RECOVERY:      recovery_q      <= cfg_wr.data;
				owms_pkg::CFG_SLOT:          slot_q          <= cfg_wr.data;
				owms_pkg::CFG_WRITE_LOW:     write_low_q     <= cfg_wr.data[5:0];
				owms_pkg::CFG_READ_SAMPLE:   read_sample_q   <= cfg_wr.data[5:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer state advances once per tick taken from the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			low_temp_q  <= '0;
			high_temp_q <= '0;
			step_q      <= '0;
			active_q    <= '0;
		end else if (q_take) begin
			phase_q     <= ph;
			tick_q      <= tc;
			bit_q       <= bc;
			shift_q     <= sb;
			low_temp_q  <= lt;
			high_temp_q <= ht;
			step_q      <= st;
			active_q    <= ac;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/owms_resq.sv -----
// ------------------------------------------------------------------------------------------
// owms_resq: result queue of the single-wire bus master
// Holds finished tick results until the consumer takes them, so that the
// sequencer keeps running while the output side stalls, until the queue is full.
// ------------------------------------------------------------------------------------------
`default_nettype none

module owms_resq (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   res_push,
	input  owms_pkg::out_item_t   res_item,
	output logic                  res_full,
	output logic                  empty,
	input  wire                   pop,
	output owms_pkg::out_item_t   out_data
);

	localparam logic [owms_pkg::RPtrW-1:0] RPtrOne = owms_pkg::RPtrW'(1);
	localparam logic [owms_pkg::RCntW-1:0] RCntOne = owms_pkg::RCntW'(1);

	owms_pkg::out_item_t          rq_mem_q [owms_pkg::RDepth];
	logic [owms_pkg::RPtrW-1:0]   wr_ptr_q;
	logic [owms_pkg::RPtrW-1:0]   rd_ptr_q;
	logic [owms_pkg::RCntW-1:0]   count_q;
	logic                         do_push;
	logic                         do_pop;

	assign res_full = (count_q == owms_pkg::RCntW'(owms_pkg::RDepth));
	assign empty    = (count_q == '0);
	assign out_data = rq_mem_q[rd_ptr_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	// Result storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			rq_mem_q[wr_ptr_q] <= res_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + RPtrOne;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + RPtrOne;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + RCntOne;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - RCntOne;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/one_wire_master_sequencer.sv -----
// The block evaluates one bus tick per clock cycle, sustained: every tick
// pushed in yields exactly one result, and a new tick is taken in every cycle
// while the result queue has room. A tick is registered in the input queue,
// evaluated by the sequencer, and its result is registered in the result queue
// before it is visible on the output. The rate is set by the sequencer state
// machine, which updates its phase, tick counter and shift register once per
// tick. The timing registers are written through the configuration channel,
// which is always ready; writes to indexes beyond the register list are ignored.
// ------------------------------------------------------------------------------------------
// one_wire_master_sequencer: single-wire bus master, one tick per transfer
// Input queue and classifier, bus sequencer and result queue.
// ------------------------------------------------------------------------------------------
`default_nettype none

module one_wire_master_sequencer (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	output logic                  full,
	input  owms_pkg::in_item_t    in_data,
	output logic                  empty,
	input  wire                   pop,
	output owms_pkg::out_item_t   out_data,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire [2:0]             cfg_index,
	input  wire [9:0]             cfg_data
);

	logic                  q_valid;
	owms_pkg::cls_item_t   q_item;
	logic                  q_take;
	logic                  res_full;
	logic                  res_push;
	owms_pkg::out_item_t   res_item;
	owms_pkg::cfg_write_t  cfg_wr;

	// Configuration writes complete in the cycle they are presented.
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	owms_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_data (in_data),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_take  (q_take)
	);

	owms_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_take   (q_take),
		.res_full (res_full),
		.res_push (res_push),
		.res_item (res_item)
	);

	owms_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_item (res_item),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

// ----- rtl/core/owms_checker.sv -----
// ------------------------------------------------------------------------------------------
// owms_checker: port-level checks of the single-wire bus master
// Watches the result side for status combinations the sequencer never makes
// and for waiting results that change, and is bound to the top level.
// ------------------------------------------------------------------------------------------
`default_nettype none

module owms_checker (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire                   full,
	input  owms_pkg::in_item_t    in_data,
	input  wire                   empty,
	input  wire                   pop,
	input  owms_pkg::out_item_t   out_data,
	input  wire                   cfg_valid,
	input  wire                   cfg_ready,
	input  wire [2:0]             cfg_index,
	input  wire [9:0]             cfg_data
);

	// A completing tick is always a busy tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.done_res) |-> out_data.busy_res)
		else $error("done result without busy");

	// Read data is zero on every tick that does not complete a command.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_data.done_res) |-> (out_data.read_data == 16'h0000))
		else $error("read data outside a completing tick");

	// The bus is released whenever no command is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_data.busy_res) |-> out_data.line_release)
		else $error("bus pulled low while idle");

	// A waiting result stays in place until it is transferred out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_data)))
		else $error("waiting result changed before transfer");

endmodule

bind one_wire_master_sequencer owms_checker u_owms_checker (.*);

`default_nettype wire
